// File: sv/bigram_frequency_max_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bigram frequency block
// Shared concurrent-assertion forms, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BIGRAM_FREQUENCY_MAX_TOP_ASSERT_SVH
`define BIGRAM_FREQUENCY_MAX_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BFM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfm: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define BFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfm: next-cycle check failed");

`endif

// File: sv/bfm_pkg.sv
// ----------------------------------------------------------------------------
// Bigram frequency package
// Request, pair and result types and the default sizes of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfm_pkg;

  localparam int unsigned ALPHABET_DEF     = 26;
  localparam int unsigned COUNT_BITS_DEF   = 16;
  localparam int unsigned LETTER_W         = 5;
  localparam int unsigned RESULT_COUNT_W   = 16;
  localparam int unsigned RESULT_COUNT_MAX = 65535;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // One letter request from the input side.
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } in_req_t;

  // A classified pair on its way from the front end to the counting engine.
  typedef struct packed {
    logic                pair_ok;
    logic                last;
    logic [LETTER_W-1:0] first_letter;
    logic [LETTER_W-1:0] second_letter;
  } pair_req_t;

  // One result per string.
  typedef struct packed {
    logic [LETTER_W-1:0]       first_letter;
    logic [LETTER_W-1:0]       second_letter;
    logic [RESULT_COUNT_W-1:0] best_count;
    logic                      found;
  } result_t;

endpackage

// File: sv/bfm_fifo.sv
// ----------------------------------------------------------------------------
// Bigram frequency queue
// Small first-in first-out buffer used between the stages of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfm_fifo #(
  parameter type ITEM_T = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  ITEM_T item_i,
  output logic  full_o,
  input  logic  pop_i,
  output ITEM_T item_o,
  output logic  empty_o
);
  import bfm_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ITEM_T            slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = CNT_W'(count_q + CNT_W'(do_push) - CNT_W'(do_pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: sv/bfm_front.sv
// ----------------------------------------------------------------------------
// Bigram frequency front end
// Accepts letters, pairs each with the one before it and classifies the pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfm_front #(
  parameter int unsigned ALPHABET = bfm_pkg::ALPHABET_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bfm_pkg::in_req_t   req_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output bfm_pkg::pair_req_t q_data_o
);
  import bfm_pkg::*;

  logic [LETTER_W-1:0] prev_q, prev_d;
  logic                have_prev_q, have_prev_d;
  logic                accept, cur_ok, prev_ok;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  // A letter beyond the alphabet still becomes the previous letter, but no
  // pair that involves it is counted.
  always_comb begin
    cur_ok                  = (32'(req_i.letter) < ALPHABET);
    prev_ok                 = (32'(prev_q) < ALPHABET);
    q_data_o.pair_ok        = have_prev_q && prev_ok && cur_ok;
    q_data_o.last           = req_i.last;
    q_data_o.first_letter   = prev_q;
    q_data_o.second_letter  = req_i.letter;
    prev_d                  = prev_q;
    have_prev_d             = have_prev_q;
    if (accept) begin
      prev_d      = req_i.last ? '0 : req_i.letter;
      have_prev_d = !req_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

// File: sv/bfm_back.sv
// ----------------------------------------------------------------------------
// Bigram frequency counting engine
// Read-modify-write of the pair count table, running maximum and table clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfm_back #(
  parameter int unsigned ALPHABET   = bfm_pkg::ALPHABET_DEF,
  parameter int unsigned COUNT_BITS = bfm_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  bfm_pkg::pair_req_t q_head_i,
  output logic               q_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output bfm_pkg::result_t   res_o
);
  import bfm_pkg::*;

  `include "bigram_frequency_max_top_assert.svh"

  localparam int unsigned SLOTS  = ALPHABET * ALPHABET;
  localparam int unsigned PAIR_W = $clog2(SLOTS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [PAIR_W-1:0]     LAST_SLOT = PAIR_W'(SLOTS - 1);

  logic [COUNT_BITS-1:0] count_mem_q [SLOTS];
  logic [COUNT_BITS-1:0] rdata_q;

  pair_req_t             b_q;
  logic                  b_valid_q, b_valid_d;
  logic [PAIR_W-1:0]     b_idx_q;

  logic                  fwd_valid_q;
  logic [PAIR_W-1:0]     fwd_idx_q;
  logic [COUNT_BITS-1:0] fwd_cnt_q;

  logic [COUNT_BITS-1:0] top_cnt_q, top_cnt_nx;
  logic [LETTER_W-1:0]   top_first_q, top_first_nx;
  logic [LETTER_W-1:0]   top_second_q, top_second_nx;

  logic                  clear_busy_q, clear_busy_d;
  logic [PAIR_W-1:0]     clear_addr_q, clear_addr_d;

  logic [PAIR_W-1:0]     head_idx, rd_addr;
  logic                  b_stall, b_adv, item_we, top_upd;
  logic [COUNT_BITS-1:0] old_cnt, new_cnt;
  logic                  mem_we;
  logic [PAIR_W-1:0]     mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;

  // Address of the pair at the queue head; the read is issued on the pop.
  always_comb begin
    head_idx = PAIR_W'(PAIR_W'(q_head_i.first_letter) * PAIR_W'(ALPHABET)
                       + PAIR_W'(q_head_i.second_letter));
    rd_addr  = q_head_i.pair_ok ? head_idx : '0;
  end

  // A string's last pair holds the stage until its result has room, and the
  // next string waits until the table has been swept back to zero.
  always_comb begin
    b_stall   = b_valid_q && b_q.last && res_full_i;
    b_adv     = b_valid_q && !b_stall;
    q_pop_o   = !q_empty_i && !clear_busy_q && !(b_valid_q && b_q.last);
    b_valid_d = q_pop_o || b_stall;
  end

  // The pair written last is not yet in the registered read data; a stalled
  // stage keeps that write in view until it moves on.
  always_comb begin
    old_cnt = (fwd_valid_q && (fwd_idx_q == b_idx_q)) ? fwd_cnt_q : rdata_q;
    new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : COUNT_BITS'(old_cnt + 1'b1);
    item_we = b_adv && b_q.pair_ok;
    top_upd = item_we && (new_cnt >= top_cnt_q);
    top_cnt_nx    = top_upd ? new_cnt : top_cnt_q;
    top_first_nx  = top_upd ? b_q.first_letter : top_first_q;
    top_second_nx = top_upd ? b_q.second_letter : top_second_q;
  end

  always_comb begin
    res_push_o         = b_adv && b_q.last;
    res_o.first_letter  = top_first_nx;
    res_o.second_letter = top_second_nx;
    res_o.found         = (top_cnt_nx != '0);
    if ((COUNT_BITS > RESULT_COUNT_W) && (32'(top_cnt_nx) > RESULT_COUNT_MAX)) begin
      res_o.best_count = '1;
    end else begin
      res_o.best_count = RESULT_COUNT_W'(top_cnt_nx);
    end
  end

  always_comb begin
    clear_busy_d = clear_busy_q;
    clear_addr_d = clear_addr_q;
    if (clear_busy_q) begin
      clear_addr_d = PAIR_W'(clear_addr_q + 1'b1);
      if (clear_addr_q == LAST_SLOT) begin
        clear_busy_d = 1'b0;
      end
    end else if (res_push_o) begin
      clear_busy_d = 1'b1;
      clear_addr_d = '0;
    end
    mem_we = clear_busy_q || item_we;
    mem_wa = clear_busy_q ? clear_addr_q : b_idx_q;
    mem_wd = clear_busy_q ? '0 : new_cnt;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem_q[mem_wa] <= mem_wd;
    end
    if (q_pop_o) begin
      rdata_q <= count_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_q     <= q_head_i;
      b_idx_q <= rd_addr;
    end
    if (!b_stall) begin
      fwd_idx_q <= b_idx_q;
      fwd_cnt_q <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q    <= 1'b0;
      fwd_valid_q  <= 1'b0;
      top_cnt_q    <= '0;
      top_first_q  <= '0;
      top_second_q <= '0;
      clear_busy_q <= 1'b1;
      clear_addr_q <= '0;
    end else begin
      b_valid_q    <= b_valid_d;
      if (!b_stall) begin
        fwd_valid_q <= item_we;
      end
      clear_busy_q <= clear_busy_d;
      clear_addr_q <= clear_addr_d;
      if (res_push_o) begin
        top_cnt_q    <= '0;
        top_first_q  <= '0;
        top_second_q <= '0;
      end else begin
        top_cnt_q    <= top_cnt_nx;
        top_first_q  <= top_first_nx;
        top_second_q <= top_second_nx;
      end
    end
  end

  `BFM_ASSERT_SAME(a_no_pop_while_clearing, clear_busy_q, !q_pop_o)
  `BFM_ASSERT_SAME(a_result_only_on_last, res_push_o, b_valid_q && b_q.last)
  `BFM_ASSERT_NEXT(a_clear_follows_result, res_push_o, clear_busy_q && (clear_addr_q == '0))
  `BFM_ASSERT_SAME(a_item_write_not_in_clear, item_we, !clear_busy_q)
  `BFM_ASSERT_SAME(a_write_in_range, mem_we, 32'(mem_wa) < SLOTS)

endmodule

// File: sv/bigram_frequency_max_top.sv
// ----------------------------------------------------------------------------
// Bigram frequency maximum
// Counts the adjacent in-alphabet letter pairs of a string and reports the most frequent.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake     Payload
//   letters   in         push / full   req_i    (letter, last)
//   results   out        pop / empty   result_o (first_letter, second_letter,
//                                               best_count, found)
//
// Within a string the block takes one letter request per cycle; the count
// table has one read and one write port, with one read-modify-write per letter,
// and a one-entry forward covers the same pair arriving in back-to-back cycles.
// After reset and after the last letter of every string the engine sweeps
// all ALPHABET*ALPHABET entries (676 by default) to zero, one entry per cycle;
// letters of the next string queue up meanwhile, and full rises once the
// two-entry input queue is occupied.
// A result waits in a two-entry output queue; only a string's last letter
// stalls when that queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bigram_frequency_max_top #(
  parameter int unsigned ALPHABET   = bfm_pkg::ALPHABET_DEF,
  parameter int unsigned COUNT_BITS = bfm_pkg::COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  bfm_pkg::in_req_t req_i,
  output logic             full,
  input  logic             pop,
  output bfm_pkg::result_t result_o,
  output logic             empty
);
  import bfm_pkg::*;

  // Front end to engine: classified pair requests.
  logic      pq_push, pq_full, pq_empty, pq_pop;
  pair_req_t pq_in, pq_head;

  // Engine to output queue: one result per string.
  logic      rq_push, rq_full;
  result_t   rq_in;

  bfm_front #(
    .ALPHABET (ALPHABET)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .req_i    (req_i),
    .q_full_i (pq_full),
    .q_push_o (pq_push),
    .q_data_o (pq_in)
  );

  // The input side sees the pair queue directly, so letters keep flowing
  // while the engine is busy clearing or waiting on the result side.
  bfm_fifo #(
    .ITEM_T (pair_req_t)
  ) u_pair_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pq_push),
    .item_i  (pq_in),
    .full_o  (pq_full),
    .pop_i   (pq_pop),
    .item_o  (pq_head),
    .empty_o (pq_empty)
  );

  assign full = pq_full;

  bfm_back #(
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (pq_empty),
    .q_head_i   (pq_head),
    .q_pop_o    (pq_pop),
    .res_full_i (rq_full),
    .res_push_o (rq_push),
    .res_o      (rq_in)
  );

  // Output queue: keeps finished results apart from the engine.
  bfm_fifo #(
    .ITEM_T (result_t)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .item_i  (rq_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .item_o  (result_o),
    .empty_o (empty)
  );

endmodule

// File: test/bigram_frequency_max_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bigram frequency maximum testbench
// Drives letter strings into the block through its queue-style input and
// checks every result against a cycle-free predictor of the most frequent
// adjacent pair. Covers directed corner strings, a long result-side
// hold-off that backs up the input, and random strings.
// ----------------------------------------------------------------------------

module bigram_frequency_max_top_tb;
  import bfm_pkg::*;

  localparam int unsigned ALPHABET       = ALPHABET_DEF;
  localparam int unsigned COUNT_BITS     = COUNT_BITS_DEF;
  localparam int unsigned PAIR_SLOTS     = ALPHABET * ALPHABET;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int unsigned RANDOM_ITEMS   = 510;
  // The result side stops popping for this long while strings keep coming.
  localparam int unsigned HOLD_CYCLES    = 4000;
  // Covers one full table sweep plus the output queue after the last result.
  localparam int unsigned TAIL_CYCLES    = 1000;
  // Longest legal silence is the hold-off plus a sweep; this is well above.
  localparam int unsigned STALL_LIMIT    = 20000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // Predicts the result of each string and holds the results still owed.
  class bigram_tracker;
    logic [COUNT_BITS-1:0] pair_counts [PAIR_SLOTS];
    logic [LETTER_W-1:0]   prev_letter;
    bit                    have_prev;
    logic [COUNT_BITS-1:0] top_count;
    int unsigned           top_slot;
    result_t               pending_results [$];
    int unsigned           mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (pair_counts[i]) pair_counts[i] = '0;
      prev_letter = '0;
      have_prev   = 1'b0;
      top_count   = '0;
      top_slot    = 0;
    endfunction

    function void note_letter(in_req_t req);
      result_t               res;
      logic [COUNT_BITS-1:0] bumped;
      int unsigned           slot;
      // Pairs that touch a letter outside the alphabet are never counted.
      if (have_prev && prev_letter < ALPHABET && req.letter < ALPHABET) begin
        slot   = prev_letter * ALPHABET + req.letter;
        bumped = pair_counts[slot];
        if (bumped != COUNT_MAX) bumped = bumped + 1'b1;
        pair_counts[slot] = bumped;
        // Ties go to the pair that reached the top count most recently.
        if (bumped >= top_count) begin
          top_count = bumped;
          top_slot  = slot;
        end
      end
      prev_letter = req.letter;
      have_prev   = 1'b1;
      if (req.last) begin
        res = '0;
        if (top_count != 0) begin
          res.first_letter  = LETTER_W'(top_slot / ALPHABET);
          res.second_letter = LETTER_W'(top_slot % ALPHABET);
          res.best_count    = (top_count > RESULT_COUNT_MAX) ?
                              RESULT_COUNT_W'(RESULT_COUNT_MAX) :
                              RESULT_COUNT_W'(top_count);
          res.found         = 1'b1;
        end
        pending_results.push_back(res);
        restart();
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      extra;
      want  = '0;
      extra = (pending_results.size() == 0);
      if (!extra) want = pending_results.pop_front();
      if (extra || got.first_letter !== want.first_letter ||
          got.second_letter !== want.second_letter ||
          got.best_count !== want.best_count || got.found !== want.found) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"%0t: %s result: expected %0d-%0d count %0d found %0d,",
                    " got %0d-%0d count %0d found %0d"},
                   $time, extra ? "unexpected" : "wrong", want.first_letter,
                   want.second_letter, want.best_count, want.found,
                   got.first_letter, got.second_letter, got.best_count, got.found);
      end
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  in_req_t req_i;
  logic    full;
  logic    pop;
  result_t result_o;
  logic    empty;

  bigram_tracker tracker;
  int unsigned   word_q [$];
  // Set by the stimulus thread; the result side picks it up on its next request.
  bit            hold_results;
  // Both sides skip their random gaps while this is set.
  bit            no_idle;
  int unsigned   stall_cycles;

  bigram_frequency_max_top #(
    .ALPHABET  (ALPHABET),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .req_i   (req_i),
    .full    (full),
    .pop     (pop),
    .result_o(result_o),
    .empty   (empty)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one letter request after a gap and holds it until it is taken.
  // push is left high so that a gap-free next request follows without a bubble.
  task automatic send_letter(input logic [LETTER_W-1:0] code, input logic is_last,
                             input int unsigned gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= '{letter: code, last: is_last};
    do @(posedge clk_i); while (full);
  endtask

  // Sends word_q as one string, with the last mark on its final letter.
  task automatic send_word();
    for (int i = 0; i < word_q.size(); i++)
      send_letter(LETTER_W'(word_q[i]), i == word_q.size() - 1,
                  no_idle ? 0 : $urandom_range(0, 5));
  endtask

  // Stops offering and waits until every owed result has been popped. The first
  // edge lets the monitor note a request that was taken at the current edge.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Sampling happens on the edge before any of this edge's updates land, so
  // both handshakes are seen with the values that the block actually saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) tracker.check_result(result_o);
      if (push && !full) tracker.note_letter(req_i);
    end
  end

  // Watchdog: any accepted request on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: a random gap before each pop, or one long hold-off on request.
  initial begin : result_side
    int unsigned gap;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned len;
    int unsigned base;
    int unsigned spread;
    int unsigned roll;
    bit          broken;
    tracker      = new();
    rst_ni       = 1'b0;
    push         = 1'b0;
    req_i        = '0;
    hold_results = 1'b0;
    no_idle      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A one-letter string holds no pair, so found stays clear.
    word_q = '{0};
    send_word();
    // Highest letter paired with itself.
    word_q = '{25, 25};
    send_word();
    // Several letters, all outside the alphabet: still no pair counted.
    word_q = '{31, 26, 31};
    send_word();
    // A letter outside the alphabet in mid-string blocks both pairs around it.
    word_q = '{3, 30, 4, 4};
    send_word();
    // The same pair in consecutive cycles exercises the count forwarding.
    no_idle = 1'b1;
    word_q = '{7, 7, 7, 7};
    send_word();
    no_idle = 1'b0;
    // Two pairs tie at two; the one that got there last wins.
    word_q = '{21, 10, 21, 10, 10, 21};
    send_word();
    // Every pair ties at one; the final pair wins.
    word_q = '{1, 2, 3, 4};
    send_word();

    // The result side holds off while short strings keep arriving, so the
    // output queue fills, the last letter stalls and full rises.
    wait_drained();
    hold_results = 1'b1;
    no_idle      = 1'b1;
    repeat (6) begin
      word_q.delete();
      repeat ($urandom_range(1, 3)) word_q.push_back($urandom_range(0, ALPHABET - 1));
      send_word();
    end
    no_idle = 1'b0;
    // The sender pauses here until every owed result has come out.
    wait_drained();

    // Random strings. Most draw from a narrow window of letters so that pairs
    // repeat and ties occur; some carry stray letters outside the alphabet, and
    // a few are pure noise over the whole five-bit range.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      word_q.delete();
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      base   = $urandom_range(0, ALPHABET - 1);
      spread = $urandom_range(1, 4);
      broken = ($urandom_range(0, 9) == 0);
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (broken || roll < 4) word_q.push_back($urandom_range(0, 31));
        else if (roll < 12) word_q.push_back($urandom_range(ALPHABET, 31));
        else word_q.push_back((base + $urandom_range(0, spread - 1)) % ALPHABET);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      send_word();
      random_items += len;
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
